// File: sv/nls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nls_pkg;

  localparam int COORD_W       = 16;
  localparam int QIDX_W        = 6;
  localparam int CAP_W         = 7;
  localparam int SQ_W          = 32;
  localparam int DIST_W        = 33;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NO_OTHER  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_SCAN
  } nls_state_t;

  // control half of the search token that ripples down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: sv/nls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nls_in_if;
  import nls_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [QIDX_W-1:0]         query_index;

  modport source (output valid, op, coord_x, coord_y, query_index, input ready);
  modport sink (input valid, op, coord_x, coord_y, query_index, output ready);
endinterface

`default_nettype wire

// File: sv/nls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nls_out_if;
  import nls_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [QIDX_W-1:0] nearest_index;
  logic [DIST_W-1:0] nearest_sq_distance;

  modport source (output valid, status, nearest_index, nearest_sq_distance, input ready);
  modport sink (input valid, status, nearest_index, nearest_sq_distance, output ready);
endinterface

`default_nettype wire

// File: sv/nls_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module nls_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 wr_en,
  input  wire  [CNT_W-1:0]                    cnt,
  input  wire  signed [nls_pkg::COORD_W-1:0]  wr_x,
  input  wire  signed [nls_pkg::COORD_W-1:0]  wr_y,
  input  wire  signed [nls_pkg::COORD_W-1:0]  q_x,
  input  wire  signed [nls_pkg::COORD_W-1:0]  q_y,
  input  wire  [nls_pkg::QIDX_W-1:0]          q_idx,
  input  wire  nls_pkg::tok_ctl_t             ctl_in,
  input  wire  [nls_pkg::DIST_W-1:0]          best_d_in,
  input  wire  [IDX_W-1:0]                    best_idx_in,
  output nls_pkg::tok_ctl_t                   ctl_out,
  output logic [nls_pkg::DIST_W-1:0]          best_d_out,
  output logic [IDX_W-1:0]                    best_idx_out,
  output logic signed [nls_pkg::COORD_W-1:0]  pt_x,
  output logic signed [nls_pkg::COORD_W-1:0]  pt_y
);
  import nls_pkg::*;

  localparam int CMP_W = (IDX_W > QIDX_W) ? IDX_W : QIDX_W;

  logic signed [COORD_W-1:0] pt_x_r, pt_y_r;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [2*COORD_W+1:0] px2, py2;
  logic [SQ_W-1:0]           sq_x_r, sq_y_r;
  logic [DIST_W-1:0]         cur_d;
  logic                      part_en;
  logic                      take;
  tok_ctl_t                  ctl_r;
  logic [DIST_W-1:0]         best_d_r;
  logic [IDX_W-1:0]          best_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en && (cnt == CNT_W'(IDX))) begin
      pt_x_r <= wr_x;
      pt_y_r <= wr_y;
    end
  end

  // squares follow the broadcast query point and are registered
  assign dx  = {q_x[COORD_W-1], q_x} - {pt_x_r[COORD_W-1], pt_x_r};
  assign dy  = {q_y[COORD_W-1], q_y} - {pt_y_r[COORD_W-1], pt_y_r};
  assign px2 = dx * dx;
  assign py2 = dy * dy;

  always_ff @(posedge clk) begin
    sq_x_r <= px2[SQ_W-1:0];
    sq_y_r <= py2[SQ_W-1:0];
  end

  assign cur_d   = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign part_en = ctl_in.valid && (CNT_W'(IDX) < cnt) && (CMP_W'(IDX) != CMP_W'(q_idx));
  // strict less-than keeps the lower index on a tie
  assign take    = part_en && (!ctl_in.found || (cur_d < best_d_in));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
      ctl_r.found <= ctl_in.found || take;
    end
  end

  always_ff @(posedge clk) begin
    best_d_r   <= take ? cur_d : best_d_in;
    best_idx_r <= take ? IDX_W'(IDX) : best_idx_in;
  end

  assign ctl_out      = ctl_r;
  assign best_d_out   = best_d_r;
  assign best_idx_out = best_idx_r;
  assign pt_x         = pt_x_r;
  assign pt_y         = pt_y_r;

endmodule

`default_nettype wire

// File: sv/nearest_location_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Brute-force 2D nearest-neighbor table. Points live one per cell in a row of
// STORE_DEPTH cells; a query loads the named point, broadcasts it to every cell,
// and sends a search token down the row, one cell per cycle; each filled cell
// but the queried one folds its squared distance into the running best (ties
// keep the lower index). For add, clear, the unused op and rejected queries
// the result is registered at the accepting edge. A searched query steps through
// S_LOAD, S_SQ and S_SCAN; the next word can be taken when the result lands
// if the output is ready. The user writes capacity_limit through cfg_wr_en /
// cfg_wr_data only while idle; the block does not enforce it.
module nearest_location_search_core #(
  parameter int STORE_DEPTH = nls_pkg::DEPTH_DEFAULT
) (
  input  wire                       clk,
  input  wire                       rst_n,
  nls_in_if.sink                    in_ch,
  nls_out_if.source                 out_ch,
  input  wire                       cfg_wr_en,
  input  wire  [nls_pkg::CAP_W-1:0] cfg_wr_data
);
  import nls_pkg::*;

  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int QW    = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;

  nls_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CAP_W-1:0]          cap_r;
  logic [QIDX_W-1:0]         qidx_r, qidx_nxt;
  logic signed [COORD_W-1:0] qpt_x_r, qpt_y_r;
  tok_ctl_t                  launch_r, launch_nxt;

  logic              out_vld_r, out_vld_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [QIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;

  logic in_acc;
  logic room;
  logic bad_idx;
  logic no_other;
  logic query_go;
  logic wr_en;

  tok_ctl_t                  ctl_c  [STORE_DEPTH+1];
  logic [DIST_W-1:0]         dist_c [STORE_DEPTH+1];
  logic [IDX_W-1:0]          idx_c  [STORE_DEPTH+1];
  logic signed [COORD_W-1:0] pt_x_c [STORE_DEPTH];
  logic signed [COORD_W-1:0] pt_y_c [STORE_DEPTH];

  assign in_ch.ready = (state_r == S_IDLE) && (!out_vld_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign room     = (CW'(cnt_r) < CW'(cap_r)) && (CW'(cnt_r) < CW'(STORE_DEPTH));
  assign bad_idx  = QW'(in_ch.query_index) >= QW'(cnt_r);
  assign no_other = cnt_r < CNT_W'(2);
  assign query_go = in_acc && (in_ch.op == OP_QUERY) && !bad_idx && !no_other;
  assign wr_en    = in_acc && (in_ch.op == OP_ADD) && room;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (query_go) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SCAN;
      S_SCAN: if (ctl_c[STORE_DEPTH].valid) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result word
  always_comb begin
    cnt_nxt      = cnt_r;
    qidx_nxt     = qidx_r;
    launch_nxt   = '0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_st_nxt   = out_st_r;
    out_idx_nxt  = out_idx_r;
    out_dist_nxt = out_dist_r;

    if (in_acc) begin
      out_idx_nxt  = '0;
      out_dist_nxt = '0;
      out_st_nxt   = ST_OK;
      unique case (in_ch.op)
        OP_ADD: begin
          out_vld_nxt = 1'b1;
          if (room) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            out_st_nxt = ST_FULL;
          end
        end
        OP_QUERY: begin
          qidx_nxt = in_ch.query_index;
          if (bad_idx) begin
            out_vld_nxt = 1'b1;
            out_st_nxt  = ST_BAD_INDEX;
          end else if (no_other) begin
            out_vld_nxt = 1'b1;
            out_st_nxt  = ST_NO_OTHER;
          end
        end
        OP_CLEAR: begin
          out_vld_nxt = 1'b1;
          cnt_nxt     = '0;
        end
        default: out_vld_nxt = 1'b1;
      endcase
    end

    if (state_r == S_SQ) begin
      launch_nxt.valid = 1'b1;
    end

    if ((state_r == S_SCAN) && ctl_c[STORE_DEPTH].valid) begin
      out_vld_nxt  = 1'b1;
      out_st_nxt   = ST_OK;
      out_idx_nxt  = QIDX_W'(idx_c[STORE_DEPTH]);
      out_dist_nxt = dist_c[STORE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cap_r     <= CAP_RESET;
      launch_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      launch_r  <= launch_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    qidx_r     <= qidx_nxt;
    out_st_r   <= out_st_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
    if (state_r == S_LOAD) begin
      qpt_x_r <= pt_x_c[IDX_W'(qidx_r)];
      qpt_y_r <= pt_y_c[IDX_W'(qidx_r)];
    end
  end

  assign ctl_c[0]  = launch_r;
  assign dist_c[0] = '0;
  assign idx_c[0]  = '0;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    nls_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr_en        (wr_en),
      .cnt          (cnt_r),
      .wr_x         (in_ch.coord_x),
      .wr_y         (in_ch.coord_y),
      .q_x          (qpt_x_r),
      .q_y          (qpt_y_r),
      .q_idx        (qidx_r),
      .ctl_in       (ctl_c[i]),
      .best_d_in    (dist_c[i]),
      .best_idx_in  (idx_c[i]),
      .ctl_out      (ctl_c[i+1]),
      .best_d_out   (dist_c[i+1]),
      .best_idx_out (idx_c[i+1]),
      .pt_x         (pt_x_c[i]),
      .pt_y         (pt_y_c[i])
    );
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.status              = out_st_r;
  assign out_ch.nearest_index       = out_idx_r;
  assign out_ch.nearest_sq_distance = out_dist_r;

  a_tok_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_c[STORE_DEPTH].valid |-> (state_r == S_SCAN))
    else $error("search token left the row outside a scan");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cnt_r) <= CW'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    query_go |=> (state_r == S_LOAD) && !out_vld_r)
    else $error("accepted query did not start a search");

  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && ctl_c[STORE_DEPTH].valid) |->
      ctl_c[STORE_DEPTH].found ##1 (out_vld_r && (out_st_r == ST_OK)))
    else $error("finished scan produced no neighbor word");

endmodule

`default_nettype wire
